// File: design/eps_pkg.sv
// Shared constants, codes and types for the exact byte pattern search block.
package eps_pkg;

    localparam int MAX_PATTERN_DEF   = 64;
    localparam int POSITION_BITS_DEF = 32;

    localparam int PLEN_W     = 7;
    localparam int PIDX_W     = 6;
    localparam int OFFSET_W   = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET   = 1'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [PIDX_W-1:0] pattern_index;
        logic [7:0]        byte_value;
        logic              first_byte;
        logic              last_byte;
    } eps_item_t;

endpackage

// File: design/eps_cfg.sv
// Configuration registers: effective pattern length, window shift, compare mask, start offset.
module eps_cfg
    import eps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1),
    parameter int IDX_W       = $clog2(MAX_PATTERN)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [LEN_W-1:0]       len,
    output logic [IDX_W-1:0]       shift,
    output logic [MAX_PATTERN-1:0] mask,
    output logic [OFFSET_W-1:0]    offset
);

    logic [LEN_W-1:0]       len_reg, len_next;
    logic [IDX_W-1:0]       shift_reg, shift_next;
    logic [MAX_PATTERN-1:0] mask_reg, mask_next;
    logic [OFFSET_W-1:0]    offset_reg, offset_next;
    logic [31:0]            eff;

    always_comb
    begin
        // zero means one byte, anything above the store depth is clamped
        eff = 32'(cfg_data[PLEN_W-1:0]);
        if (eff == 32'd0)
        begin
            eff = 32'd1;
        end
        else if (eff > 32'(MAX_PATTERN))
        begin
            eff = 32'(MAX_PATTERN);
        end

        len_next    = len_reg;
        shift_next  = shift_reg;
        mask_next   = mask_reg;
        offset_next = offset_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH:
                begin
                    len_next   = LEN_W'(eff);
                    shift_next = IDX_W'(32'(MAX_PATTERN) - eff);
                    mask_next  = ~({MAX_PATTERN{1'b1}} << eff);
                end
                REG_START_OFFSET:
                begin
                    offset_next = cfg_data[OFFSET_W-1:0];
                end
                default:
                begin
                    offset_next = offset_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= LEN_W'(1);
            shift_reg  <= IDX_W'(MAX_PATTERN - 1);
            mask_reg   <= MAX_PATTERN'(1);
            offset_reg <= '0;
        end
        else
        begin
            len_reg    <= len_next;
            shift_reg  <= shift_next;
            mask_reg   <= mask_next;
            offset_reg <= offset_next;
        end
    end

    assign len    = len_reg;
    assign shift  = shift_reg;
    assign mask   = mask_reg;
    assign offset = offset_reg;

endmodule

// File: design/eps_pattern.sv
// Pattern byte store, written by load requests, read in parallel by the comparator.
module eps_pattern
    import eps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [PIDX_W-1:0]        wr_slot,
    input  logic [7:0]               wr_byte,
    output logic [MAX_PATTERN*8-1:0] pattern
);

    logic [7:0] store_reg [MAX_PATTERN];

    // slots past the store depth are dropped
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (wr_en && (32'(wr_slot) == k))
            begin
                store_reg[k] <= wr_byte;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            pattern[k*8 +: 8] = store_reg[k];
        end
    end

endmodule

// File: design/eps_window.sv
// Data history shift line and saturating byte counter.
module eps_window
    import eps_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     first,
    input  logic [7:0]               data_byte,
    output logic [MAX_PATTERN*8-1:0] hist_upd,
    output logic [POSITION_BITS-1:0] seen_upd
);

    // newest byte sits in the top lane, oldest in lane 0
    logic [MAX_PATTERN*8-1:0] hist_reg, hist_next;
    logic [POSITION_BITS-1:0] seen_reg, seen_next;

    always_comb
    begin
        if (first)
        begin
            hist_upd = {data_byte, {(MAX_PATTERN*8-8){1'b0}}};
            seen_upd = POSITION_BITS'(1);
        end
        else
        begin
            hist_upd = {data_byte, hist_reg[MAX_PATTERN*8-1:8]};
            seen_upd = (&seen_reg) ? seen_reg : seen_reg + POSITION_BITS'(1);
        end
        hist_next = advance ? hist_upd : hist_reg;
        seen_next = advance ? seen_upd : seen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            seen_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
            seen_reg <= seen_next;
        end
    end

endmodule

// File: design/eps_compare.sv
// Window versus pattern compare and match position check.
module eps_compare
    import eps_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LEN_W         = $clog2(MAX_PATTERN + 1),
    parameter int IDX_W         = $clog2(MAX_PATTERN)
)
(
    input  logic [MAX_PATTERN*8-1:0] hist,
    input  logic [MAX_PATTERN*8-1:0] pattern,
    input  logic [POSITION_BITS-1:0] seen,
    input  logic [LEN_W-1:0]         len,
    input  logic [IDX_W-1:0]         shift,
    input  logic [MAX_PATTERN-1:0]   mask,
    input  logic [OFFSET_W-1:0]      offset,
    output logic                     hit,
    output logic [POSITION_BITS-1:0] start
);

    localparam int CMP_W = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;

    logic [MAX_PATTERN*8-1:0] aligned;
    logic [MAX_PATTERN-1:0]   eq;
    logic [POSITION_BITS-1:0] len_ext;

    // lane j of aligned is the byte that pattern byte j must equal
    assign aligned = hist >> {shift, 3'b000};
    assign len_ext = POSITION_BITS'(len);
    assign start   = seen - len_ext;

    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            eq[j] = (aligned[j*8 +: 8] == pattern[j*8 +: 8]) || !mask[j];
        end
    end

    assign hit = (&eq) && (seen >= len_ext) && (CMP_W'(start) >= CMP_W'(offset));

endmodule

// File: design/exact_byte_pattern_search_top.sv
// Exact byte pattern search: request intake, search control and result register.
//
// Usage: requests arrive on in_valid/in_ready. A request with operation LOAD
// writes byte_value into pattern slot pattern_index; a DATA request shifts one
// data byte into the search window. first_byte starts a new search, last_byte
// ends it. Each search gives one result on out_valid/out_ready: found=1 with
// the position of the earliest match at or after start_offset, or found=0 at
// the last byte. Configuration (pattern_length, start_offset) is written on
// cfg_write with cfg_index/cfg_data while no request is in flight.
// Path: the accepting edge loads the input register; the window compare of that
// request is loaded into the result register once the result register is free.
// Throughput: one request per cycle while the result register is free, set by the
// combinational window compare.
// A stalled receiver holds the result register; one further request is taken
// into the input register and then in_ready drops until the result leaves.
// Reset clears the window, byte count, search state, pipeline valids and
// configuration (length 1, offset 0); pattern bytes are undefined until loaded.
module exact_byte_pattern_search_top
    import eps_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic [PIDX_W-1:0]        pattern_index,
    input  logic [7:0]               byte_value,
    input  logic                     first_byte,
    input  logic                     last_byte,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     found,
    output logic [POSITION_BITS-1:0] match_position,
    output logic [POSITION_BITS-1:0] next_start,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = $clog2(MAX_PATTERN);

    logic                     in_vld_reg, in_vld_next;
    eps_item_t                item_reg, item_next;
    logic                     done_reg, done_next;
    logic                     out_vld_reg, out_vld_next;
    logic                     found_reg, found_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] nxt_reg, nxt_next;

    logic                     out_free, fire, data_fire, load_fire;
    logic                     done_eff, hit, emit;
    logic [LEN_W-1:0]         len;
    logic [IDX_W-1:0]         shift;
    logic [MAX_PATTERN-1:0]   mask;
    logic [OFFSET_W-1:0]      offset;
    logic [MAX_PATTERN*8-1:0] pattern;
    logic [MAX_PATTERN*8-1:0] hist_upd;
    logic [POSITION_BITS-1:0] seen_upd, start;

    assign out_free  = !out_vld_reg || out_ready;
    assign fire      = in_vld_reg && out_free;
    assign in_ready  = !in_vld_reg || out_free;
    assign data_fire = fire && (item_reg.operation == OP_DATA);
    assign load_fire = fire && (item_reg.operation == OP_LOAD);

    eps_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W),
        .IDX_W       (IDX_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .len       (len),
        .shift     (shift),
        .mask      (mask),
        .offset    (offset)
    );

    eps_pattern #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_pattern (
        .clk     (clk),
        .wr_en   (load_fire && (32'(item_reg.pattern_index) < MAX_PATTERN)),
        .wr_slot (item_reg.pattern_index),
        .wr_byte (item_reg.byte_value),
        .pattern (pattern)
    );

    eps_window #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (data_fire),
        .first     (item_reg.first_byte),
        .data_byte (item_reg.byte_value),
        .hist_upd  (hist_upd),
        .seen_upd  (seen_upd)
    );

    eps_compare #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS),
        .LEN_W         (LEN_W),
        .IDX_W         (IDX_W)
    ) u_compare (
        .hist    (hist_upd),
        .pattern (pattern),
        .seen    (seen_upd),
        .len     (len),
        .shift   (shift),
        .mask    (mask),
        .offset  (offset),
        .hit     (hit),
        .start   (start)
    );

    assign done_eff = item_reg.first_byte ? 1'b0 : done_reg;
    assign emit     = data_fire && !done_eff && (hit || item_reg.last_byte);

    always_comb
    begin
        in_vld_next = in_vld_reg;
        item_next   = item_reg;
        if (in_valid && in_ready)
        begin
            in_vld_next = 1'b1;
            item_next   = '{operation:     operation,
                            pattern_index: pattern_index,
                            byte_value:    byte_value,
                            first_byte:    first_byte,
                            last_byte:     last_byte};
        end
        else if (fire)
        begin
            in_vld_next = 1'b0;
        end

        done_next = done_reg;
        if (data_fire)
        begin
            done_next = done_eff || hit || item_reg.last_byte;
        end

        out_vld_next = out_vld_reg && !out_ready;
        found_next   = found_reg;
        pos_next     = pos_reg;
        nxt_next     = nxt_reg;
        if (emit)
        begin
            out_vld_next = 1'b1;
            found_next   = hit;
            pos_next     = hit ? start : '0;
            nxt_next     = hit ? start + POSITION_BITS'(1) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            done_reg    <= done_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
        nxt_reg   <= nxt_next;
    end

    assign out_valid      = out_vld_reg;
    assign found          = found_reg;
    assign match_position = pos_reg;
    assign next_start     = nxt_reg;

endmodule

// File: tb/tb.sv
// Testbench for exact_byte_pattern_search_top: random search streams checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import eps_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned BLOCK_ITEMS = 110;
    localparam int unsigned LONG_STALL  = 300;

    localparam logic [6:0]  BLOCK_LEN [9] = '{7'd1, 7'd3, 7'd64, 7'd0, 7'd8,
                                              7'd127, 7'd5, 7'd2, 7'd16};
    localparam logic [31:0] BLOCK_OFFSET [9] = '{32'd0, 32'd2, 32'd0, 32'hFFFF_FFFF,
                                                 32'd1, 32'd0, 32'd0, 32'd0, 32'd3};

    typedef struct packed {
        logic        hit;
        logic [31:0] position;
        logic [31:0] resume;
    } search_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    eps_item_t             drv_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  found;
    logic [31:0]           match_position;
    logic [31:0]           next_start;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    eps_item_t      pending_q [$];
    search_result_t expected_results [$];

    // predictor state
    logic [7:0]  pat_image [0:63];
    logic [7:0]  win_image [0:63];
    logic [31:0] byte_count = '0;
    bit          search_closed = 1'b0;
    logic [6:0]  len_reg = 7'd1;
    logic [31:0] offset_reg = '0;

    // generator's view of the pattern slots
    logic [7:0]  gen_pat [0:63];

    int unsigned send_idle_pct = 9;
    int unsigned recv_idle_pct = 87;
    int unsigned queued_items = 0;
    int unsigned results_checked = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    int          stall_mark = -1;
    int unsigned stall_left = 0;
    bit          stall_taken = 1'b0;

    exact_byte_pattern_search_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (drv_item.operation),
        .pattern_index  (drv_item.pattern_index),
        .byte_value     (drv_item.byte_value),
        .first_byte     (drv_item.first_byte),
        .last_byte      (drv_item.last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .match_position (match_position),
        .next_start     (next_start),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned eff_len(input logic [6:0] raw);
        if (raw == 7'd0)
            return 1;
        if (raw > 7'd64)
            return 64;
        return 32'(raw);
    endfunction

    task automatic apply_request(input eps_item_t req);
        int unsigned plen;
        logic [31:0] origin;
        bit          hit;
        if (req.operation == OP_LOAD)
        begin
            pat_image[req.pattern_index] = req.byte_value;
            return;
        end
        if (req.first_byte)
        begin
            foreach (win_image[i])
                win_image[i] = 8'h00;
            byte_count = '0;
            search_closed = 1'b0;
        end
        for (int i = 63; i > 0; i--)
            win_image[i] = win_image[i-1];
        win_image[0] = req.byte_value;
        if (byte_count != '1)
            byte_count++;
        if (search_closed)
            return;
        plen = eff_len(len_reg);
        if (byte_count >= plen)
        begin
            origin = byte_count - plen;
            hit = (origin >= offset_reg);
            // newest byte sits at window slot 0 and lines up with the last pattern byte
            for (int i = 0; i < plen; i++)
                if (win_image[i] != pat_image[plen - 1 - i])
                    hit = 1'b0;
            if (hit)
            begin
                search_closed = 1'b1;
                expected_results.push_back('{1'b1, origin, origin + 32'd1});
                return;
            end
        end
        if (req.last_byte)
        begin
            search_closed = 1'b1;
            expected_results.push_back('{1'b0, 32'd0, 32'd0});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            drv_item <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_request(drv_item);
            if (!in_valid || in_ready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    drv_item <= pending_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        search_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result found=%0b pos=%0d next=%0d",
                             $time, found, match_position, next_start);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (found !== want.hit)
                    begin
                        $display("%0t: found expected %0b actual %0b", $time, want.hit, found);
                        errors++;
                    end
                    if (match_position !== want.position)
                    begin
                        $display("%0t: match_position expected %0d actual %0d",
                                 $time, want.position, match_position);
                        errors++;
                    end
                    if (next_start !== want.resume)
                    begin
                        $display("%0t: next_start expected %0d actual %0d",
                                 $time, want.resume, next_start);
                        errors++;
                    end
                    results_checked++;
                end
            end
            // long hold-off so the block backs up into its input
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!stall_taken && stall_mark >= 0 && results_checked >= stall_mark)
            begin
                stall_taken = 1'b1;
                stall_left = LONG_STALL;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_load(input logic [5:0] slot, input logic [7:0] value);
        pending_q.push_back('{OP_LOAD, slot, value, 1'($urandom_range(1)),
                              1'($urandom_range(1))});
        gen_pat[slot] = value;
        queued_items++;
    endtask

    task automatic queue_data(input logic [7:0] value, input bit first, input bit last);
        pending_q.push_back('{OP_DATA, 6'($urandom_range(63)), value, first, last});
        queued_items++;
    endtask

    task automatic reload_pattern(input int unsigned plen);
        bit themed;
        themed = 1'($urandom_range(1));
        // two-letter patterns overlap themselves, which tests earliest-match selection
        for (int i = 0; i < plen; i++)
            queue_load(6'(i), themed ? ($urandom_range(1) ? 8'hA5 : 8'h5A)
                                     : 8'($urandom_range(255)));
    endtask

    task automatic queue_search(input int unsigned plen);
        logic [7:0]  stream [$];
        int unsigned n;
        int unsigned spot;
        bit          themed;
        bit          abandon;
        n = $urandom_range(1) ? $urandom_range(1, plen + 16) : plen + $urandom_range(16);
        themed = 1'($urandom_range(1));
        abandon = ($urandom_range(9) == 0);
        for (int i = 0; i < n; i++)
            stream.push_back(themed ? gen_pat[$urandom_range(plen - 1)]
                                    : 8'($urandom_range(255)));
        if ($urandom_range(9) < 6 && n >= plen)
        begin
            spot = $urandom_range(n - plen);
            for (int j = 0; j < plen; j++)
                stream[spot + j] = gen_pat[j];
        end
        for (int i = 0; i < n; i++)
            queue_data(stream[i], i == 0, (i == n - 1) && !abandon);
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_q.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_search(input logic [6:0] plen, input logic [31:0] offset);
        write_reg(REG_PATTERN_LENGTH, {25'd0, plen});
        write_reg(REG_START_OFFSET, offset);
        len_reg = plen;
        offset_reg = offset;
        @(negedge clk);
    endtask

    task automatic run_block(input int unsigned k);
        int unsigned plen;
        int unsigned target;
        int unsigned pick;
        drain();
        set_search(BLOCK_LEN[k], (k == 6) ? $urandom() : BLOCK_OFFSET[k]);
        plen = eff_len(BLOCK_LEN[k]);
        reload_pattern(k == 0 ? 64 : plen);
        if (k == 7)
            stall_mark = int'(results_checked) + 3;
        target = queued_items + BLOCK_ITEMS;
        while (queued_items < target)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                queue_search(plen);
            else if (pick < 85)
                queue_load(6'($urandom_range(63)), 8'($urandom_range(255)));
            else if (pick < 95)
                queue_data(8'($urandom_range(255)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            else
                reload_pattern(plen);
        end
    endtask

    initial
    begin
        foreach (win_image[i])
            win_image[i] = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // length 1, offset 0 out of reset
        queue_load(6'd0, 8'hFF);
        queue_load(6'd63, 8'h00);
        queue_data(8'h00, 1'b0, 1'b0);      // stream opens without a first-byte mark
        queue_data(8'hFF, 1'b0, 1'b0);      // hit at position 1
        queue_data(8'hFF, 1'b0, 1'b1);      // search already closed: silent
        queue_data(8'h12, 1'b1, 1'b0);
        queue_data(8'hFF, 1'b0, 1'b1);      // hit on the final byte, no not-found after it
        queue_data(8'h00, 1'b1, 1'b1);      // one-byte file, no hit
        queue_load(6'd1, 8'hAB);
        drain();
        set_search(7'd2, 32'd1);
        queue_data(8'hFF, 1'b1, 1'b0);
        queue_data(8'hAB, 1'b0, 1'b0);      // hit at 0 lies below the offset
        queue_data(8'hFF, 1'b0, 1'b0);
        queue_data(8'hAB, 1'b0, 1'b0);      // hit at 2
        queue_data(8'h01, 1'b1, 1'b1);      // file shorter than the pattern
        queue_data(8'hFF, 1'b1, 1'b0);      // leave a search open across a register write
        drain();
        set_search(7'd2, 32'hFFFF_FFFF);
        queue_data(8'hAB, 1'b0, 1'b1);

        for (int ph = 0; ph < 3; ph++)
        begin
            for (int sub = 0; sub < 3; sub++)
            begin
                if (sub == 0)
                begin
                    drain();
                    send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 87 : 0;
                    recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 9 : 0;
                end
                run_block(ph * 3 + sub);
            end
        end

        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
design/eps_pkg.sv
design/eps_cfg.sv
design/eps_pattern.sv
design/eps_window.sv
design/eps_compare.sv
design/exact_byte_pattern_search_top.sv
tb/tb.sv
